### hdl/smac_pkg.sv
// ----------------------------------------------------------------------------
// smac_pkg
// Shared constants for the moving-average crossover signal block: register
// indexes, signal codes and register reset values.
// ----------------------------------------------------------------------------
package smac_pkg;

  localparam int unsigned LEN_BITS     = 7;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CODE_BITS    = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_LEN = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_LEN  = CFG_IDX_BITS'(1);

  localparam logic [CODE_BITS-1:0] SIG_NONE = CODE_BITS'(0);
  localparam logic [CODE_BITS-1:0] SIG_LONG = CODE_BITS'(1);
  localparam logic [CODE_BITS-1:0] SIG_EXIT = CODE_BITS'(2);

  localparam logic [LEN_BITS-1:0] SHORT_LEN_RST = LEN_BITS'(10);
  localparam logic [LEN_BITS-1:0] LONG_LEN_RST  = LEN_BITS'(30);

endpackage

### hdl/smac_ram.sv
// ----------------------------------------------------------------------------
// smac_ram
// Generic single-write, single-read RAM with a registered, read-first output.
// ----------------------------------------------------------------------------
module smac_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/smac_window.sv
// ----------------------------------------------------------------------------
// smac_window
// Price history ring and running window sums. Writes each price into the
// ring, reads the two prices leaving the windows and updates both sums.
// ----------------------------------------------------------------------------
module smac_window import smac_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned PRICE_BITS = 32,
  localparam int unsigned AW = $clog2(MAX_WINDOW),
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1),
  localparam int unsigned LW = (CW > LEN_BITS) ? CW : LEN_BITS,
  localparam int unsigned SW = PRICE_BITS + AW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  logic [LW-1:0]         short_len_i,
  input  logic [LW-1:0]         long_len_i,
  input  logic [LW-1:0]         need_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PRICE_BITS-1:0] price_i,
  output logic                  item_valid_o,
  input  logic                  take_i,
  output logic [SW-1:0]         short_sum_o,
  output logic [SW-1:0]         long_sum_o,
  output logic                  warm_o
);

  logic [AW-1:0] slot_q, slot_d;
  logic [CW-1:0] count_q, count_d, count_inc;
  logic [AW-1:0] idx_s, idx_l;
  logic [LW:0]   base_s, base_l;
  logic          accept, s1_free, s2_free, s1_adv;

  logic                  s1_valid_q;
  logic [PRICE_BITS-1:0] s1_price_q;
  logic                  s1_sub_s_q, s1_sub_l_q, s1_warm_q;
  logic [PRICE_BITS-1:0] rd_s, rd_l;

  logic          s2_valid_q;
  logic [SW-1:0] short_sum_q, short_sum_d;
  logic [SW-1:0] long_sum_q, long_sum_d;
  logic          s2_warm_q;

  // pipeline flow
  assign s2_free    = !s2_valid_q || take_i;
  assign s1_free    = !s1_valid_q || s2_free;
  assign s1_adv     = s1_valid_q && s2_free;
  assign accept     = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;

  // ring addresses of the prices leaving each window
  always_comb begin
    base_s = (LW+1)'(slot_q) + (LW+1)'(MAX_WINDOW) - (LW+1)'(short_len_i);
    base_l = (LW+1)'(slot_q) + (LW+1)'(MAX_WINDOW) - (LW+1)'(long_len_i);
    if (base_s >= (LW+1)'(MAX_WINDOW)) begin
      base_s = base_s - (LW+1)'(MAX_WINDOW);
    end
    if (base_l >= (LW+1)'(MAX_WINDOW)) begin
      base_l = base_l - (LW+1)'(MAX_WINDOW);
    end
    idx_s = base_s[AW-1:0];
    idx_l = base_l[AW-1:0];
  end

  always_comb begin
    count_inc = (count_q == CW'(MAX_WINDOW)) ? count_q : count_q + CW'(1);
    slot_d    = slot_q;
    count_d   = count_q;
    if (restart_i) begin
      slot_d  = '0;
      count_d = '0;
    end else if (accept) begin
      slot_d  = (slot_q == AW'(MAX_WINDOW - 1)) ? '0 : slot_q + AW'(1);
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      count_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      count_q <= count_d;
      if (s1_free) begin
        s1_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_price_q <= price_i;
      s1_sub_s_q <= LW'(count_q) >= short_len_i;
      s1_sub_l_q <= LW'(count_q) >= long_len_i;
      s1_warm_q  <= LW'(count_inc) >= need_i;
    end
  end

  smac_ram #(
    .WIDTH(PRICE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring_short (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(slot_q),
    .wdata_i(price_i),
    .re_i   (accept),
    .raddr_i(idx_s),
    .rdata_o(rd_s)
  );

  smac_ram #(
    .WIDTH(PRICE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring_long (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(slot_q),
    .wdata_i(price_i),
    .re_i   (accept),
    .raddr_i(idx_l),
    .rdata_o(rd_l)
  );

  // running sums, old price out and new price in
  always_comb begin
    short_sum_d = short_sum_q + SW'(s1_price_q)
                - (s1_sub_s_q ? SW'(rd_s) : SW'(0));
    long_sum_d  = long_sum_q + SW'(s1_price_q)
                - (s1_sub_l_q ? SW'(rd_l) : SW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      short_sum_q <= '0;
      long_sum_q  <= '0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (restart_i) begin
        short_sum_q <= '0;
        long_sum_q  <= '0;
      end else if (s1_adv) begin
        short_sum_q <= short_sum_d;
        long_sum_q  <= long_sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_warm_q <= s1_warm_q;
    end
  end

  assign item_valid_o = s2_valid_q;
  assign short_sum_o  = short_sum_q;
  assign long_sum_o   = long_sum_q;
  assign warm_o       = s2_warm_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WINDOW))
    else $error("sample count above window maximum");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (count_q == '0 && slot_q == '0 && short_sum_q == '0 && long_sum_q == '0))
    else $error("history not cleared after restart");

  a_ring_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_free) |=> ($stable(rd_s) && $stable(rd_l)))
    else $error("ring read data lost while stage is held");

endmodule

### hdl/smac_decide.sv
// ----------------------------------------------------------------------------
// smac_decide
// Cross-multiplies the window sums with the opposite window lengths,
// compares the products and tracks the position flag.
// ----------------------------------------------------------------------------
module smac_decide import smac_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned PRICE_BITS = 32,
  localparam int unsigned AW = $clog2(MAX_WINDOW),
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1),
  localparam int unsigned LW = (CW > LEN_BITS) ? CW : LEN_BITS,
  localparam int unsigned SW = PRICE_BITS + AW,
  localparam int unsigned PW = SW + LW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [LW-1:0]        short_len_i,
  input  logic [LW-1:0]        long_len_i,
  input  logic                 item_valid_i,
  output logic                 take_o,
  input  logic [SW-1:0]        short_sum_i,
  input  logic [SW-1:0]        long_sum_i,
  input  logic                 warm_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CODE_BITS-1:0] signal_code_o,
  output logic                 in_position_o,
  output logic                 warmed_up_o
);

  logic          s3_valid_q, s3_warm_q;
  logic [PW-1:0] prod_s_q, prod_l_q;
  logic          s3_free, s4_free, s4_load;

  logic                 out_valid_q, warm_q, holding_q, holding_d;
  logic [CODE_BITS-1:0] code_q, code_d;

  assign s4_free = !out_valid_q || !out_stall_i;
  assign s3_free = !s3_valid_q || s4_free;
  assign s4_load = s3_valid_q && s4_free;
  assign take_o  = s3_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_free) begin
      s3_valid_q <= item_valid_i;
    end
  end

  // short mean against long mean, as sum times the other length
  always_ff @(posedge clk_i) begin
    if (item_valid_i && s3_free) begin
      prod_s_q  <= PW'(short_sum_i) * PW'(long_len_i);
      prod_l_q  <= PW'(long_sum_i) * PW'(short_len_i);
      s3_warm_q <= warm_i;
    end
  end

  always_comb begin
    code_d    = SIG_NONE;
    holding_d = holding_q;
    if (s3_warm_q) begin
      if (prod_s_q > prod_l_q && !holding_q) begin
        code_d    = SIG_LONG;
        holding_d = 1'b1;
      end else if (prod_s_q < prod_l_q && holding_q) begin
        code_d    = SIG_EXIT;
        holding_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      holding_q   <= 1'b0;
    end else begin
      if (s4_free) begin
        out_valid_q <= s3_valid_q;
      end
      if (s4_load) begin
        holding_q <= holding_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_load) begin
      code_q <= code_d;
      warm_q <= s3_warm_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign signal_code_o = code_q;
  assign in_position_o = holding_q;
  assign warmed_up_o   = warm_q;

  a_signal_needs_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && signal_code_o != SIG_NONE) |-> warmed_up_o)
    else $error("signal given before warm-up");

  a_position_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((signal_code_o != SIG_LONG || in_position_o) &&
                     (signal_code_o != SIG_EXIT || !in_position_o)))
    else $error("position flag disagrees with signal");

  a_holding_moves_on_signal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(holding_q) |-> (out_valid_o &&
      (signal_code_o == SIG_LONG || signal_code_o == SIG_EXIT)))
    else $error("position changed without a signal");

endmodule

### hdl/sma_crossover_signal.sv
// ----------------------------------------------------------------------------
// sma_crossover_signal
// Moving-average crossover detector over a stream of prices.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with one price_i per beat. Output
// channel: out_valid_o / out_stall_i, one beat per input beat carrying
// signal_code_o (none, enter long, exit), in_position_o and warmed_up_o.
// A beat moves on a rising edge with valid high and stall low.
// Input beats pass registered stages in order: ring read, window sum update,
// cross-multiply, compare. One beat is taken every cycle while in_stall_o is
// low; the rate is set by the two ring memories, each with one write and one
// read port, so every price costs two writes and two reads in the same cycle.
// cfg_we_i writes short_len (index 0) or long_len (index 1) and restarts the
// price history; the position flag is kept. Other indexes are ignored.
// Write configuration only while no beat is in flight.
// Reset sets the windows to 10 and 30, empties the history and goes flat.
// The ring needs no clearing pass. When out_stall_i is high the result and
// the three stages behind it hold; in_stall_o rises once all are full.
// ----------------------------------------------------------------------------
module sma_crossover_signal import smac_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [LEN_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [PRICE_BITS-1:0]   price_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CODE_BITS-1:0]    signal_code_o,
  output logic                    in_position_o,
  output logic                    warmed_up_o
);

  localparam int unsigned AW = $clog2(MAX_WINDOW);
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned LW = (CW > LEN_BITS) ? CW : LEN_BITS;
  localparam int unsigned SW = PRICE_BITS + AW;

  logic [LEN_BITS-1:0] short_len_q, long_len_q;
  logic [LW-1:0]       short_eff, long_eff, need;
  logic                restart;
  logic                item_valid, take, warm;
  logic [SW-1:0]       short_sum, long_sum;

  assign restart = cfg_we_i && (cfg_idx_i == CFG_SHORT_LEN || cfg_idx_i == CFG_LONG_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len_q <= SHORT_LEN_RST;
      long_len_q  <= LONG_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHORT_LEN: short_len_q <= cfg_data_i;
        CFG_LONG_LEN:  long_len_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // zero acts as one, above the ring depth acts as the depth
  always_comb begin
    if (short_len_q == '0) begin
      short_eff = LW'(1);
    end else if (LW'(short_len_q) > LW'(MAX_WINDOW)) begin
      short_eff = LW'(MAX_WINDOW);
    end else begin
      short_eff = LW'(short_len_q);
    end
    if (long_len_q == '0) begin
      long_eff = LW'(1);
    end else if (LW'(long_len_q) > LW'(MAX_WINDOW)) begin
      long_eff = LW'(MAX_WINDOW);
    end else begin
      long_eff = LW'(long_len_q);
    end
    need = (short_eff > long_eff) ? short_eff : long_eff;
  end

  smac_window #(
    .MAX_WINDOW(MAX_WINDOW),
    .PRICE_BITS(PRICE_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .short_len_i (short_eff),
    .long_len_i  (long_eff),
    .need_i      (need),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .price_i     (price_i),
    .item_valid_o(item_valid),
    .take_i      (take),
    .short_sum_o (short_sum),
    .long_sum_o  (long_sum),
    .warm_o      (warm)
  );

  smac_decide #(
    .MAX_WINDOW(MAX_WINDOW),
    .PRICE_BITS(PRICE_BITS)
  ) u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .short_len_i  (short_eff),
    .long_len_i   (long_eff),
    .item_valid_i (item_valid),
    .take_o       (take),
    .short_sum_i  (short_sum),
    .long_sum_i   (long_sum),
    .warm_i       (warm),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .signal_code_o(signal_code_o),
    .in_position_o(in_position_o),
    .warmed_up_o  (warmed_up_o)
  );

endmodule

### tb/sma_crossover_signal_test.sv
// ----------------------------------------------------------------------------
// sma_crossover_signal_test
// Self-checking bench for the moving-average crossover detector. A local
// predictor keeps its own price ring, window sums and position flag and
// works out every result. Directed beats cover warm-up, entry, exit, equal
// means, clamped window lengths and ignored register indexes. Random phases
// then cover many window settings with trending price walks, bursty input
// and a stalling receiver.
// ----------------------------------------------------------------------------
module sma_crossover_signal_test;
  import smac_pkg::*;

  localparam int unsigned WIN_MAX       = 64;
  localparam int unsigned PX_BITS       = 32;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_PRICES = 1335;
  localparam longint      PX_TOP        = (longint'(1) << PX_BITS) - 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = CFG_IDX_BITS'(3);

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 in_pos;
    logic                 warm;
  } signal_beat_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [LEN_BITS-1:0]     cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [PX_BITS-1:0]      price_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [CODE_BITS-1:0]    signal_code_o;
  logic                    in_position_o;
  logic                    warmed_up_o;

  // predictor state
  logic [PX_BITS-1:0]  px_ring [WIN_MAX];
  logic [5:0]          ring_slot;
  int unsigned         fill_cnt;
  logic [39:0]         short_total;
  logic [39:0]         long_total;
  logic                holding_pos;
  logic [LEN_BITS-1:0] short_reg;
  logic [LEN_BITS-1:0] long_reg;
  signal_beat_t        pending_q [$];

  // stimulus and bookkeeping
  logic [PX_BITS-1:0] walk_px;
  logic               walk_up;
  int unsigned        walk_step;
  int unsigned        gap_max;
  int unsigned        burst_left;
  logic               stall_on;
  int unsigned        stall_run;
  int unsigned        cycle_cnt;
  int unsigned        sent_cnt;
  int unsigned        checked_cnt;
  int unsigned        entry_cnt;
  int unsigned        exit_cnt;
  int unsigned        warm_cnt;
  int unsigned        write_cnt;
  int unsigned        miss_cnt;
  signal_beat_t       seen_beat;
  signal_beat_t       want_beat;

  sma_crossover_signal #(
    .MAX_WINDOW(WIN_MAX),
    .PRICE_BITS(PX_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .price_i      (price_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .signal_code_o(signal_code_o),
    .in_position_o(in_position_o),
    .warmed_up_o  (warmed_up_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned span_of(input logic [LEN_BITS-1:0] v);
    if (v == '0) return 1;
    if (v > WIN_MAX) return WIN_MAX;
    return 32'(v);
  endfunction

  function automatic signal_beat_t next_signal(input logic [PX_BITS-1:0] px);
    int unsigned  sl;
    int unsigned  ll;
    int unsigned  need;
    logic [47:0]  lhs;
    logic [47:0]  rhs;
    signal_beat_t r;
    sl   = span_of(short_reg);
    ll   = span_of(long_reg);
    need = (sl > ll) ? sl : ll;
    // drop the prices leaving each window before the slot is overwritten
    if (fill_cnt >= sl) short_total -= 40'(px_ring[6'(ring_slot - sl)]);
    if (fill_cnt >= ll) long_total -= 40'(px_ring[6'(ring_slot - ll)]);
    short_total += 40'(px);
    long_total  += 40'(px);
    px_ring[ring_slot] = px;
    ring_slot++;
    if (fill_cnt < WIN_MAX) fill_cnt++;
    r.code = SIG_NONE;
    r.warm = (fill_cnt >= need);
    if (r.warm) begin
      lhs = 48'(short_total) * 48'(ll);
      rhs = 48'(long_total) * 48'(sl);
      if (lhs > rhs && !holding_pos) begin
        holding_pos = 1'b1;
        r.code = SIG_LONG;
      end else if (lhs < rhs && holding_pos) begin
        holding_pos = 1'b0;
        r.code = SIG_EXIT;
      end
    end
    r.in_pos = holding_pos;
    return r;
  endfunction

  function automatic logic [PX_BITS-1:0] pick_price();
    int unsigned sel;
    longint      v;
    sel = $urandom_range(0, 99);
    if (sel < 3) return '0;
    if (sel < 6) return '1;
    if (sel < 14) return PX_BITS'($urandom());
    if (sel < 22) return walk_px;
    if ($urandom_range(0, 11) == 0) walk_up = !walk_up;
    v = longint'(walk_px) + longint'($urandom_range(0, 32)) - 16;
    if (walk_up) v += longint'($urandom_range(0, walk_step));
    else v -= longint'($urandom_range(0, walk_step));
    if (v < 0) v = 0;
    if (v > PX_TOP) v = PX_TOP;
    walk_px = PX_BITS'(v);
    return walk_px;
  endfunction

  function automatic logic [LEN_BITS-1:0] pick_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LEN_BITS'($urandom_range(WIN_MAX + 1, (1 << LEN_BITS) - 1));
      2: return LEN_BITS'(WIN_MAX);
      default: return LEN_BITS'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic flag_error(input string what);
    miss_cnt++;
    if (miss_cnt <= 10) $display("%s", what);
  endtask

  task automatic send_price(input logic [PX_BITS-1:0] px);
    int unsigned gap;
    in_valid_i <= 1'b1;
    price_i    <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_q.insert(pending_q.size(), next_signal(px));
    sent_cnt++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (gap_max > 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(1, gap_max);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [LEN_BITS-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    write_cnt++;
    if (idx == CFG_SHORT_LEN) short_reg = val;
    else if (idx == CFG_LONG_LEN) long_reg = val;
    else return;
    // history restarts, position is kept
    ring_slot   = '0;
    fill_cnt    = 0;
    short_total = '0;
    long_total  = '0;
  endtask

  task automatic test_crossing();
    gap_max = 0;
    stall_on <= 1'b1;
    write_reg(CFG_SHORT_LEN, LEN_BITS'(2));
    write_reg(CFG_LONG_LEN, LEN_BITS'(3));
    send_price('0);
    send_price('0);
    send_price('0);
    send_price('1);
    send_price('1);
    send_price('1);
    send_price('0);
    send_price('0);
    send_price('1);
    wait_idle();
  endtask

  task automatic test_restart_and_clamp();
    write_reg(CFG_SHORT_LEN, '0);
    write_reg(CFG_LONG_LEN, '0);
    send_price('1);
    send_price('0);
    wait_idle();
    write_reg(CFG_SPARE_2, '1);
    write_reg(CFG_SPARE_3, LEN_BITS'(5));
    send_price(PX_BITS'(5));
    wait_idle();
    write_reg(CFG_LONG_LEN, '1);
    write_reg(CFG_SHORT_LEN, LEN_BITS'(1));
    send_price(PX_BITS'(32'h8000_0000));
    send_price(PX_BITS'(32'h7FFF_FFFF));
    send_price('1);
    wait_idle();
  endtask

  task automatic test_random_stream();
    int unsigned         phase;
    int unsigned         start;
    int unsigned         n;
    int unsigned         sl;
    int unsigned         ll;
    logic [LEN_BITS-1:0] s_len;
    logic [LEN_BITS-1:0] l_len;
    phase = 0;
    start = sent_cnt;
    while (sent_cnt - start < RANDOM_PRICES) begin
      wait_idle();
      case (phase)
        0: begin s_len = LEN_BITS'(1);       l_len = LEN_BITS'(WIN_MAX); end
        1: begin s_len = LEN_BITS'(WIN_MAX); l_len = LEN_BITS'(1);       end
        2: begin s_len = '0;                 l_len = '1;                 end
        3: begin s_len = '1;                 l_len = '0;                 end
        4: begin s_len = LEN_BITS'(WIN_MAX); l_len = LEN_BITS'(WIN_MAX); end
        5: begin s_len = LEN_BITS'(1);       l_len = LEN_BITS'(1);       end
        default: begin
          s_len = pick_len();
          l_len = pick_len();
        end
      endcase
      if (phase < 6 || $urandom_range(0, 3) != 0) begin
        write_reg(CFG_SHORT_LEN, s_len);
        write_reg(CFG_LONG_LEN, l_len);
      end else if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_LONG_LEN, l_len);
      end else begin
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                  LEN_BITS'($urandom()));
      end
      if (phase == 5) begin
        gap_max = 0;
        stall_on <= 1'b0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_max = 0;
          1: gap_max = 3;
          default: gap_max = 12;
        endcase
        stall_on <= ($urandom_range(0, 3) != 0);
      end
      walk_step = ($urandom_range(0, 3) == 0) ? 32'h0800_0000 : $urandom_range(16, 4096);
      if ($urandom_range(0, 1) == 0) walk_px = PX_BITS'($urandom());
      sl = span_of(short_reg);
      ll = span_of(long_reg);
      n  = ((sl > ll) ? sl : ll) + $urandom_range(10, 60);
      repeat (n) begin
        if ($urandom_range(0, 149) == 0) wait_idle();
        send_price(pick_price());
      end
      phase++;
    end
  endtask

  // receiver back-pressure, runs of stall and flow of random length
  always @(posedge clk_i) begin
    if (!stall_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_run == 0) begin
      stall_run = $urandom_range(1, 7);
      out_stall_i <= ($urandom_range(0, 2) == 0);
    end else begin
      stall_run--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_beat = '{signal_code_o, in_position_o, warmed_up_o};
      if (pending_q.size() == 0) begin
        flag_error($sformatf("unexpected beat: code %0d pos %0b warm %0b",
                             seen_beat.code, seen_beat.in_pos, seen_beat.warm));
      end else begin
        want_beat = pending_q.pop_front();
        if (seen_beat.code !== want_beat.code || seen_beat.in_pos !== want_beat.in_pos ||
            seen_beat.warm !== want_beat.warm) begin
          flag_error($sformatf(
            "beat %0d: expected code %0d pos %0b warm %0b, got code %0d pos %0b warm %0b",
            checked_cnt, want_beat.code, want_beat.in_pos, want_beat.warm,
            seen_beat.code, seen_beat.in_pos, seen_beat.warm));
        end
        if (want_beat.code == SIG_LONG) entry_cnt++;
        if (want_beat.code == SIG_EXIT) exit_cnt++;
        if (want_beat.warm) warm_cnt++;
      end
      checked_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout with %0d beats outstanding", pending_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    price_i     = '0;
    out_stall_i = 1'b0;
    stall_on    = 1'b0;
    stall_run   = 0;
    gap_max     = 0;
    burst_left  = 0;
    cycle_cnt   = 0;
    sent_cnt    = 0;
    checked_cnt = 0;
    entry_cnt   = 0;
    exit_cnt    = 0;
    warm_cnt    = 0;
    write_cnt   = 0;
    miss_cnt    = 0;
    walk_px     = 32'h4000_0000;
    walk_up     = 1'b1;
    walk_step   = 1024;
    ring_slot   = '0;
    fill_cnt    = 0;
    short_total = '0;
    long_total  = '0;
    holding_pos = 1'b0;
    short_reg   = SHORT_LEN_RST;
    long_reg    = LONG_LEN_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_crossing();
    test_restart_and_clamp();
    test_random_stream();
    wait_idle();
    if (pending_q.size() != 0) flag_error("results still outstanding at end of run");
    $display("sent %0d prices over %0d register writes, checked %0d results",
             sent_cnt, write_cnt, checked_cnt);
    $display("%0d warmed results, %0d entries, %0d exits, %0d mismatches",
             warm_cnt, entry_cnt, exit_cnt, miss_cnt);
    if (miss_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
